// ----- sv/fgu_pkg.sv -----
// Package with the types and helpers shared by the fp32 gradient unscale pipeline.
package fgu_pkg;

  localparam int DivBits = 26;              // quotient bits, hidden bit down to the bit below the round bit
  localparam logic [7:0] ExpAllOnes = 8'hFF;
  localparam logic [33:0] PosInf = 34'h07F800000;
  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_BAD_SCALE = 1'b1;

  typedef struct packed {
    logic [23:0]        mant;   // hidden bit at 23
    logic signed [10:0] expo;
  } unpack_t;

  // Sideband that rides along every stage.
  typedef struct packed {
    logic        sign;
    logic [31:0] raw;
    logic        nonfin;
    logic        bad;
    logic        zero;
    logic        found;
  } side_t;

  typedef struct packed {
    side_t              sd;
    logic [23:0]        ma;
    logic signed [10:0] e;
  } s0_t;

  typedef struct packed {
    side_t              sd;
    logic [24:0]        rem;
    logic [DivBits-1:0] q;
    logic signed [10:0] e;
  } div_t;

  typedef struct packed {
    side_t              sd;
    logic [DivBits-1:0] sig;
    logic               sticky;
    logic signed [10:0] e;
  } rs_t;

  // Unpacks a finite nonzero fp32 value; subnormals are normalized.
  function automatic unpack_t unpack_f(logic [31:0] x);
    unpack_t     u;
    logic [4:0]  p;
    logic [4:0]  sh;
    p = 5'd0;
    sh = 5'd0;
    if (x[30:23] == 8'd0) begin
      for (int i = 0; i < 23; i++) begin
        if (x[i]) p = 5'(i);
      end
      sh = 5'd23 - p;
      u.mant = {1'b0, x[22:0]} << sh;
      u.expo = 11'sd1 - $signed({6'd0, sh});
    end else begin
      u.mant = {1'b1, x[22:0]};
      u.expo = $signed({3'd0, x[30:23]});
    end
    return u;
  endfunction

endpackage

// ----- sv/fp32_gradient_unscale.sv -----
// Top level of the pipelined fp32 gradient unscale with sticky non-finite detection.
// One fp32 gradient enters per cycle and leaves divided by the loss scale, rounded
// to nearest even with subnormals kept. The stages are unpack, alignment, the
// restoring divider, which resolves one quotient bit per stage over 26 stages, a
// denormal shift and a round/pack stage. Throughput is one transaction per cycle;
// a stall on a valid output freezes the whole pipeline. NaN and infinite gradients
// pass through unchanged and, while the loss scale is valid, set the sticky inf_sticky
// flag; an invalid loss scale (non-finite, negative or zero) passes every gradient
// through with status 1. Write cfg_loss_scale only while no transaction is in flight.
module fp32_gradient_unscale
  import fgu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_loss_scale,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_grad_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_grad_out,
  output logic        out_item_nonfinite,
  output logic        out_inf_sticky,
  output logic        out_status
);

  logic [31:0] scale_r;
  logic [23:0] mb_r;
  logic        inf_seen_r, inf_seen_nxt;
  logic        adv, acc;

  s0_t   s0_r;
  logic  s0_v_r;
  div_t  dv_r [0:DivBits];
  logic  dv_v_r [0:DivBits];
  rs_t   rs_r;
  logic  rs_v_r;
  logic  out_v_r;

  unpack_t ug, us;
  logic    scale_bad, g_nonfin;

  assign adv      = !out_v_r || !out_stall;
  assign in_stall = !adv;
  assign acc      = in_valid && adv;

  always_comb begin
    us        = unpack_f(scale_r);
    ug        = unpack_f(in_grad_in);
    scale_bad = (scale_r[30:23] == ExpAllOnes) || scale_r[31] || (scale_r == 32'd0);
    g_nonfin  = in_grad_in[30:23] == ExpAllOnes;
    inf_seen_nxt = inf_seen_r | (acc && g_nonfin && !scale_bad);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r    <= 32'h3F80_0000;
      inf_seen_r <= 1'b0;
    end else begin
      if (cfg_we) scale_r <= cfg_loss_scale;
      inf_seen_r <= inf_seen_nxt;
    end
  end

  // Divisor significand is only needed from the alignment stage on.
  always_ff @(posedge clk) begin
    mb_r <= us.mant;
  end

  // Stage 0: unpack.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (adv) begin
      s0_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_r.sd.sign   <= in_grad_in[31];
      s0_r.sd.raw    <= in_grad_in;
      s0_r.sd.nonfin <= g_nonfin;
      s0_r.sd.bad    <= scale_bad;
      s0_r.sd.zero   <= in_grad_in[30:0] == 31'd0;
      s0_r.sd.found  <= inf_seen_nxt;
      s0_r.ma        <= ug.mant;
      s0_r.e         <= ug.expo - us.expo + 11'sd127;
    end
  end

  // Stage 1: align the dividend so the quotient lands in [2^25, 2^26).
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (adv) begin
      dv_v_r[0] <= s0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_r[0].sd <= s0_r.sd;
      dv_r[0].q  <= '0;
      if (s0_r.ma < mb_r) begin
        dv_r[0].rem <= {s0_r.ma, 1'b0};
        dv_r[0].e   <= s0_r.e - 11'sd1;
      end else begin
        dv_r[0].rem <= {1'b0, s0_r.ma};
        dv_r[0].e   <= s0_r.e;
      end
    end
  end

  // Restoring divider, one quotient bit per stage.
  for (genvar k = 0; k < DivBits; k++) begin : g_div
    logic [24:0] r;
    logic        ge;
    always_comb begin
      r  = (k == 0) ? dv_r[k].rem : {dv_r[k].rem[23:0], 1'b0};
      ge = r >= {1'b0, mb_r};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k+1] <= 1'b0;
      end else if (adv) begin
        dv_v_r[k+1] <= dv_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_r[k+1].sd  <= dv_r[k].sd;
        dv_r[k+1].e   <= dv_r[k].e;
        dv_r[k+1].q   <= {dv_r[k].q[DivBits-2:0], ge};
        dv_r[k+1].rem <= ge ? (r - {1'b0, mb_r}) : r;
      end
    end
  end

  // Denormal shift: results below the normal range are shifted right with sticky.
  div_t        dl;
  logic [4:0]  shv;
  logic [31:0] sig_w, mask_w;
  logic        stk;
  logic signed [10:0] e_rs;
  always_comb begin
    dl     = dv_r[DivBits];
    shv    = 5'd0;
    e_rs   = dl.e;
    stk    = dl.rem != 25'd0;
    sig_w  = {6'd0, dl.q};
    if (dl.e <= 11'sd0) begin
      shv  = (dl.e < -11'sd28) ? 5'd30 : 5'(11'sd1 - dl.e);
      e_rs = 11'sd0;
    end
    mask_w = (32'd1 << shv) - 32'd1;
    if ((sig_w & mask_w) != 32'd0) stk = 1'b1;
    sig_w  = sig_w >> shv;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rs_v_r <= 1'b0;
    end else if (adv) begin
      rs_v_r <= dv_v_r[DivBits];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rs_r.sd     <= dl.sd;
      rs_r.sig    <= sig_w[DivBits-1:0];
      rs_r.sticky <= stk;
      rs_r.e      <= e_rs;
    end
  end

  // Round to nearest even, pack, and pick the pass-through cases.
  logic [24:0] mant25;
  logic [33:0] bits;
  logic [31:0] res;
  always_comb begin
    mant25 = {1'b0, rs_r.sig[25:2]};
    if (rs_r.sig[1] && (rs_r.sig[0] || rs_r.sticky || rs_r.sig[2]))
      mant25 = mant25 + 25'd1;
    if (rs_r.e >= 11'sd1)
      bits = ({23'd0, 11'(rs_r.e - 11'sd1)} << 23) + {9'd0, mant25};
    else
      bits = {9'd0, mant25};
    if (bits >= PosInf) bits = PosInf;
    if (rs_r.sd.bad || rs_r.sd.nonfin)
      res = rs_r.sd.raw;
    else if (rs_r.sd.zero)
      res = {rs_r.sd.sign, 31'd0};
    else
      res = {rs_r.sd.sign, bits[30:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= rs_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_grad_out       <= res;
      out_item_nonfinite <= rs_r.sd.nonfin;
      out_inf_sticky     <= rs_r.sd.found;
      out_status         <= rs_r.sd.bad ? STATUS_BAD_SCALE : STATUS_OK;
    end
  end

  assign out_valid = out_v_r;

`ifndef SYNTH
  a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(inf_seen_r) && $past(rst_n) |-> inf_seen_r)
    else $error("inf_sticky flag dropped without reset");

  a_nonfin_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item_nonfinite && (out_status == STATUS_OK) |-> out_inf_sticky)
    else $error("non-finite gradient did not set inf_sticky");

  a_nonfin_pass: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item_nonfinite |-> out_grad_out[30:23] == ExpAllOnes)
    else $error("non-finite gradient was altered");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output is free");
`endif

endmodule
